// ----- hw/rtl/depth_tested_point_plotter_defines.svh -----
// assertion macros used by the checker file
`ifndef DEPTH_TESTED_POINT_PLOTTER_DEFINES_SVH
`define DEPTH_TESTED_POINT_PLOTTER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DTPP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("point plotter check failed");

// consequent must hold in the cycle after the antecedent
`define DTPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("point plotter check failed");

`endif

// ----- hw/rtl/dtpp_pkg.sv -----
// types, codes and tables shared by the point plotter modules
package dtpp_pkg;

    // request kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_PLOT  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam int CFG_IW = 8;
    localparam logic [CFG_IW-1:0] CFG_CAMERA = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_NEAR   = 8'd1;
    localparam logic [CFG_IW-1:0] CFG_CSCALE = 8'd2;
    localparam logic [CFG_IW-1:0] CFG_RSCALE = 8'd3;

    // configuration reset values
    localparam logic [15:0] CAMERA_RST = 16'd20480;
    localparam logic [15:0] NEAR_RST   = 16'd410;
    localparam logic [7:0]  CSCALE_RST = 8'd45;
    localparam logic [7:0]  RSCALE_RST = 8'd22;

    localparam logic [6:0]  SPACE_GLYPH = 7'd32;
    localparam logic [15:0] INV_SAT     = 16'hFFFF;
    localparam int          DIV_STEPS   = 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] brightness;
        logic [11:0]        read_cell;
    } in_item_t;

    typedef struct packed {
        logic        written;
        logic [11:0] cell_index;
        logic [6:0]  glyph;
        logic [15:0] cell_depth;
    } out_item_t;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_PLOT = 2'd1,
        RES_READ = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     div_init;
        logic     div_step;
        logic     mul_col;
        logic     mul_row;
        logic     bound;
        logic     addr;
        logic     rd_plot;
        logic     rd_cell;
        logic     plot_write;
        logic     clr_start;
        logic     clr_step;
        logic     res_load;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       drop;
        logic       div_last;
        logic       off_screen;
        logic       hit;
        logic       clr_last;
    } ctrl_status_t;

    // brightness ramp, darkest first
    function automatic logic [6:0] ramp_glyph(input logic [3:0] idx);
        logic [6:0] g;
        unique case (idx)
            4'd0:    g = 7'h2E;
            4'd1:    g = 7'h2C;
            4'd2:    g = 7'h2D;
            4'd3:    g = 7'h7E;
            4'd4:    g = 7'h3A;
            4'd5:    g = 7'h3B;
            4'd6:    g = 7'h3D;
            4'd7:    g = 7'h21;
            4'd8:    g = 7'h2A;
            4'd9:    g = 7'h23;
            4'd10:   g = 7'h24;
            4'd11:   g = 7'h40;
            default: g = 7'h40;
        endcase
        return g;
    endfunction

endpackage

// ----- hw/rtl/dtpp_ram.sv -----
// generic single write port, single read port ram with registered read
module dtpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/dtpp_ctrl.sv -----
// sequencer for the point plotter: clear sweep, plot steps, cell reads
module dtpp_ctrl import dtpp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [13:0] {
        ST_INIT  = 14'h0001,
        ST_IDLE  = 14'h0002,
        ST_CLEAR = 14'h0004,
        ST_CHECK = 14'h0008,
        ST_DIV   = 14'h0010,
        ST_MULC  = 14'h0020,
        ST_MULR  = 14'h0040,
        ST_BOUND = 14'h0080,
        ST_ADDR  = 14'h0100,
        ST_READ  = 14'h0200,
        ST_TEST  = 14'h0400,
        ST_RREQ  = 14'h0800,
        ST_RRES  = 14'h1000,
        ST_ZERO  = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;

    // next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.res_sel = RES_ZERO;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    unique case (status.kind)
                        KIND_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        KIND_PLOT: state_next = ST_CHECK;
                        KIND_READ: state_next = ST_RREQ;
                        default:   state_next = ST_ZERO;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_ZERO;
                end
            end
            ST_CHECK: begin
                if (status.drop) begin
                    state_next = ST_ZERO;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_MULC;
                end
            end
            ST_MULC: begin
                cmd.mul_col = 1'b1;
                state_next  = ST_MULR;
            end
            ST_MULR: begin
                cmd.mul_row = 1'b1;
                state_next  = ST_BOUND;
            end
            ST_BOUND: begin
                cmd.bound  = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                if (status.off_screen) begin
                    state_next = ST_ZERO;
                end else begin
                    cmd.addr   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_plot = 1'b1;
                state_next  = ST_TEST;
            end
            ST_TEST: begin
                if (out_free) begin
                    cmd.res_load   = 1'b1;
                    cmd.plot_write = status.hit;
                    cmd.res_sel    = status.hit ? RES_PLOT : RES_ZERO;
                    state_next     = ST_IDLE;
                end
            end
            ST_RREQ: begin
                cmd.rd_cell = 1'b1;
                state_next  = ST_RRES;
            end
            ST_RRES: begin
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_READ;
                    state_next   = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // output register valid flag
    always_comb begin
        if (cmd.res_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ----- hw/rtl/dtpp_datapath.sv -----
// point plotter datapath: config, reciprocal divider, projection, frame ram
module dtpp_datapath import dtpp_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 30
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  in_item_t          s_item,
    input  logic              cfg_valid,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [15:0]       cfg_data,
    input  ctrl_cmd_t         cmd,
    output ctrl_status_t      status,
    output out_item_t         m_item
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = 23;
    localparam logic signed [17:0] HALF_C = 18'(COLUMNS / 2);
    localparam logic signed [17:0] HALF_R = 18'(ROWS / 2);
    localparam logic signed [17:0] LIM_C  = 18'(COLUMNS);
    localparam logic signed [17:0] LIM_R  = 18'(ROWS);
    localparam logic [AW-1:0]      LAST_CELL = AW'(CELLS - 1);

    // configuration registers
    logic [15:0] cam_reg, cam_next;
    logic [15:0] near_reg, near_next;
    logic [7:0]  cscale_reg, cscale_next;
    logic [7:0]  rscale_reg, rscale_next;

    // item and derived operands
    in_item_t           item_reg;
    logic signed [17:0] z_reg, z_next;
    logic [23:0]        prodx_reg, prodx_next;
    logic [23:0]        prody_reg, prody_next;
    logic               negx_reg, negy_reg;
    logic [6:0]         glyph_reg, glyph_next;

    // divider
    logic [17:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [3:0]  div_cnt_reg, div_cnt_next;
    logic        sat_reg, sat_next;

    // projection and address
    logic [15:0]        tc_reg, tr_reg;
    logic signed [17:0] col_reg, col_next;
    logic signed [17:0] row_reg, row_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    out_item_t          res_reg, res_next;

    logic [15:0] magx, magy;
    logic [12:0] bclamp;
    logic [16:0] bmul;
    logic [15:0] inv;
    logic [17:0] rem_sh;
    logic        div_ge;
    logic [23:0] mul_a;
    logic [39:0] mul_p;
    logic signed [17:0] extc, extr;
    logic [15:0] idx_full;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic [6:0]  rd_glyph;
    logic [15:0] rd_depth;
    logic        rd_in_range;

    // configuration writes
    always_comb begin
        cam_next    = cam_reg;
        near_next   = near_reg;
        cscale_next = cscale_reg;
        rscale_next = rscale_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CAMERA: cam_next    = cfg_data;
                CFG_NEAR:   near_next   = cfg_data;
                CFG_CSCALE: cscale_next = cfg_data[7:0];
                CFG_RSCALE: rscale_next = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // operands formed at item capture
    always_comb begin
        magx = s_item.pos_x[15] ? (~s_item.pos_x + 16'd1) : s_item.pos_x;
        magy = s_item.pos_y[15] ? (~s_item.pos_y + 16'd1) : s_item.pos_y;
        prodx_next = 24'(cscale_reg) * 24'(magx);
        prody_next = 24'(rscale_reg) * 24'(magy);
        z_next = 18'(s_item.pos_z) + $signed({2'b00, cam_reg});
        if (s_item.brightness[15]) begin
            bclamp = 13'd0;
        end else if (s_item.brightness > 16'sd4096) begin
            bclamp = 13'd4096;
        end else begin
            bclamp = s_item.brightness[12:0];
        end
        bmul       = 17'(bclamp) * 17'd11;
        glyph_next = ramp_glyph(bmul[15:12]);
    end

    // one quotient bit per step of 2^24 / z, starting from 2^8 since z > 256
    assign inv    = sat_reg ? INV_SAT : q_reg;
    assign rem_sh = {rem_reg[16:0], 1'b0};
    assign div_ge = rem_sh >= $unsigned(z_reg);

    always_comb begin
        rem_next     = rem_reg;
        q_next       = q_reg;
        div_cnt_next = div_cnt_reg;
        sat_next     = sat_reg;
        if (cmd.div_init) begin
            rem_next     = 18'd256;
            q_next       = '0;
            div_cnt_next = '0;
            sat_next     = z_reg <= 18'sd256;
        end else if (cmd.div_step) begin
            rem_next     = div_ge ? (rem_sh - $unsigned(z_reg)) : rem_sh;
            q_next       = {q_reg[14:0], div_ge};
            div_cnt_next = div_cnt_reg + 4'd1;
        end
    end

    // shared projection multiplier, magnitude times inverse depth
    assign mul_a = cmd.mul_row ? prody_reg : prodx_reg;
    assign mul_p = 40'(mul_a) * 40'(inv);

    // signed screen position from centre
    assign extc = $signed({2'b00, tc_reg});
    assign extr = $signed({2'b00, tr_reg});
    assign col_next = negx_reg ? (HALF_C - extc) : (HALF_C + extc);
    assign row_next = negy_reg ? (HALF_R + extr) : (HALF_R - extr);

    // cell address, row and column both below 256 once on screen
    assign idx_full = 16'(row_reg[7:0]) * 16'(COLUMNS) + 16'(col_reg[7:0]);
    assign idx_next = idx_full[AW-1:0];

    // clear sweep counter
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_start) begin
            clr_cnt_next = '0;
        end else if (cmd.clr_step) begin
            clr_cnt_next = (clr_cnt_reg == LAST_CELL) ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    // frame ram holding glyph and inverse depth per cell
    assign ram_we    = cmd.clr_step || cmd.plot_write;
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clr_step ? {SPACE_GLYPH, 16'd0} : {glyph_reg, inv};
    assign ram_re    = cmd.rd_plot || cmd.rd_cell;
    assign ram_raddr = cmd.rd_cell ? AW'(item_reg.read_cell) : idx_reg;

    dtpp_ram #(
        .WIDTH (RW),
        .DEPTH (CELLS)
    ) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_glyph    = ram_rdata[RW-1:16];
    assign rd_depth    = ram_rdata[15:0];
    assign rd_in_range = 32'(item_reg.read_cell) < 32'(CELLS);

    // result selection
    always_comb begin
        res_next = res_reg;
        if (cmd.res_load) begin
            unique case (cmd.res_sel)
                RES_ZERO: res_next = '0;
                RES_PLOT: begin
                    res_next.written    = 1'b1;
                    res_next.cell_index = 12'(idx_reg);
                    res_next.glyph      = glyph_reg;
                    res_next.cell_depth = inv;
                end
                RES_READ: begin
                    res_next.written    = 1'b0;
                    res_next.cell_index = item_reg.read_cell;
                    res_next.glyph      = rd_in_range ? rd_glyph : 7'd0;
                    res_next.cell_depth = rd_in_range ? rd_depth : 16'd0;
                end
                default: res_next = '0;
            endcase
        end
    end

    // status to the sequencer
    assign status.kind       = s_item.kind;
    assign status.drop       = z_reg <= $signed({2'b00, near_reg});
    assign status.div_last   = div_cnt_reg == 4'(DIV_STEPS - 1);
    assign status.off_screen = col_reg[17] || (col_reg >= LIM_C) ||
                               row_reg[17] || (row_reg >= LIM_R);
    assign status.hit        = inv > rd_depth;
    assign status.clr_last   = clr_cnt_reg == LAST_CELL;

    // configuration and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg     <= CAMERA_RST;
            near_reg    <= NEAR_RST;
            cscale_reg  <= CSCALE_RST;
            rscale_reg  <= RSCALE_RST;
            clr_cnt_reg <= '0;
        end else begin
            cam_reg     <= cam_next;
            near_reg    <= near_next;
            cscale_reg  <= cscale_next;
            rscale_reg  <= rscale_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg  <= s_item;
            z_reg     <= z_next;
            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
            negx_reg  <= s_item.pos_x[15];
            negy_reg  <= s_item.pos_y[15];
            glyph_reg <= glyph_next;
        end
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        div_cnt_reg <= div_cnt_next;
        sat_reg     <= sat_next;
        if (cmd.mul_col) begin
            tc_reg <= mul_p[39:24];
        end
        if (cmd.mul_row) begin
            tr_reg <= mul_p[39:24];
        end
        if (cmd.bound) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
        if (cmd.addr) begin
            idx_reg <= idx_next;
        end
        res_reg <= res_next;
    end

    assign m_item = res_reg;

endmodule

// ----- hw/rtl/depth_tested_point_plotter.sv -----
// Depth-tested point plotter: projects Q4.12 points onto a COLUMNS x ROWS
// character grid with a per-cell inverse-depth test, and serves clear and
// cell-read requests. A plot request runs the bit-serial reciprocal 2^24/z,
// one quotient bit a cycle, then the shared projection multiplier, the
// bounds check, the address multiply and the read-modify-write of the
// frame ram before the next request can be accepted. A point dropped as
// too near skips the divider and all later steps, and one that lands off
// screen skips the frame ram access. A clear writes one cell a cycle
// through the ram's single write port. After reset the same sweep runs
// with s_ready low; configuration writes are always taken. A result waits
// in an output register while the next request is accepted.
module depth_tested_point_plotter import dtpp_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 30
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [15:0]       cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    dtpp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dtpp_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_item    (m_item)
    );

endmodule

// ----- hw/rtl/dtpp_checker.sv -----
// port-level checks for the point plotter, bound to the top level
`include "depth_tested_point_plotter_defines.svh"

module dtpp_checker import dtpp_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 30
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input out_item_t         m_item
);

    localparam int CELLS = COLUMNS * ROWS;

    // a stalled result holds
    `DTPP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // an accepted request keeps the block busy for at least the next cycle
    `DTPP_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready)

    // reset starts the clearing sweep with nothing to deliver
    `DTPP_ASSERT_NEXT(a_init, aclk, 1'b1, !aresetn, !s_ready && !m_valid)

    // a plotted cell carries a nonzero depth, a ramp glyph and a valid index
    `DTPP_ASSERT_NOW(a_plot, aclk, aresetn, m_valid && m_item.written, m_item.cell_depth != 16'd0 && m_item.glyph != SPACE_GLYPH && 32'(m_item.cell_index) < 32'(CELLS))

endmodule

bind depth_tested_point_plotter dtpp_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (.*);
